// ===== hdl/sxrst_pkg.sv =====
// Package for the sysex reassembler with reset detection.
// Holds buffer sizing, field widths, sysex codes and the reset-message matcher.
// No dependencies.
package sxrst_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int CNT_W        = $clog2(BUFFER_BYTES);   // holds 0 .. BUFFER_BYTES-1
    localparam int DATA_W       = 8;
    localparam int ELEN_W       = 10;
    localparam int TIME_W       = 32;
    localparam int MLEN_W       = 10;
    localparam int SUM_W        = ((CNT_W > ELEN_W) ? CNT_W : ELEN_W) + 1;
    localparam int HDR_N        = 9;

    localparam logic [DATA_W-1:0] SX_START = 8'hF0;
    localparam logic [DATA_W-1:0] SX_END   = 8'hF7;

    localparam logic                KIND_START = 1'b0;
    localparam logic                KIND_CONT  = 1'b1;

    // manufacturer / sub-id codes
    localparam logic [DATA_W-1:0] ID_GS       = 8'h41;
    localparam logic [DATA_W-1:0] ID_GS_MODEL = 8'h42;
    localparam logic [DATA_W-1:0] CMD_DT1     = 8'h12;
    localparam logic [DATA_W-1:0] ID_XG       = 8'h43;
    localparam logic [DATA_W-1:0] ID_TGMODEL  = 8'h2B;
    localparam logic [DATA_W-1:0] ID_XGMODEL  = 8'h4C;
    localparam logic [DATA_W-1:0] ID_UNIV     = 8'h7E;
    localparam logic [DATA_W-1:0] SUB_GM      = 8'h09;
    localparam logic [DATA_W-1:0] BYTE_7F     = 8'h7F;

    typedef logic [HDR_N-1:0][DATA_W-1:0] t_hdr;   // element k-1 holds message byte k

    function automatic logic detect_reset(input t_hdr h, input logic [CNT_W-1:0] len);
        logic gs_hit;
        logic xg_hit;
        logic gm_hit;
        gs_hit = 1'b0;
        xg_hit = 1'b0;
        gm_hit = 1'b0;
        if (h[2] == ID_GS_MODEL && h[3] == CMD_DT1 && len == CNT_W'(11)) begin
            if (h[4] == 8'h00 && h[5] == 8'h00 && h[6] == BYTE_7F &&
                ((h[7] == 8'h00 && h[8] == 8'h01) || (h[7] == 8'h01 && h[8] == 8'h00)))
                gs_hit = 1'b1;
            if (h[4] == 8'h40 && h[5] == 8'h00 && h[6] == BYTE_7F &&
                h[7] == 8'h00 && h[8] == ID_GS)
                gs_hit = 1'b1;
        end
        if (h[2] == ID_TGMODEL)
            xg_hit = (len == CNT_W'(10)) && h[3] == 8'h00 && h[4] == 8'h00 &&
                     h[5] == BYTE_7F && h[6] == 8'h00 && h[7] == 8'h01;
        else if (h[2] == ID_XGMODEL)
            xg_hit = (len == CNT_W'(9)) && h[3] == 8'h00 && h[4] == 8'h00 &&
                     (h[5] == ID_UNIV || h[5] == BYTE_7F) && h[6] == 8'h00;
        gm_hit = h[2] == SUB_GM && len == CNT_W'(6) &&
                 (h[3] == 8'h01 || h[3] == 8'h02 || h[3] == 8'h03);
        if (len < CNT_W'(6))
            return 1'b0;
        if (h[0] == ID_GS)
            return gs_hit;
        if (h[0] == ID_XG)
            return xg_hit;
        if (h[0] == ID_UNIV)
            return gm_hit;
        return 1'b0;
    endfunction

endpackage

// ===== hdl/sxrst_if.sv =====
// Valid/ready channel interfaces for the sysex reassembler: byte items in,
// completed-message transactions out. Depends on sxrst_pkg.
interface sxrst_in_if import sxrst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_value;
    logic                event_kind;
    logic [ELEN_W-1:0]   event_length;
    logic                first_of_event;
    logic                last_of_event;
    logic                no_payload;
    logic [TIME_W-1:0]   event_time;

    modport source (output valid, data_value, event_kind, event_length, first_of_event,
                    last_of_event, no_payload, event_time, input ready);
    modport sink   (input valid, data_value, event_kind, event_length, first_of_event,
                    last_of_event, no_payload, event_time, output ready);
endinterface

interface sxrst_out_if import sxrst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   message_time;
    logic [MLEN_W-1:0]   message_length;
    logic                is_reset;

    modport source (output valid, message_time, message_length, is_reset, input ready);
    modport sink   (input valid, message_time, message_length, is_reset, output ready);
endinterface

// ===== hdl/sysex_reassembler_reset_detect_core.sv =====
// Sysex reassembler with reset detection: top level.
// Depends on sxrst_pkg and the channel interfaces in sxrst_if.sv.
//
// Usage:
//   i_in  carries one sysex data byte per transaction, tagged with event kind
//         (start/continuation), event length, first/last marks, an empty flag
//         and the event time.
//   o_out carries one transaction per completed message: time of the closing
//         event, stored length (F0 and F7 included) and a reset-message flag.
// Pipeline: a byte is captured in the input register on the edge it is taken;
//   when it advances, the message state updates and any result is loaded into
//   the output register, from which o_out offers it.
// Throughput: one byte per cycle while o_out is not held. The limit is the
//   single state update (length counter, header bytes, last byte) done per cycle.
// Stall: while o_out is held, the input register keeps its byte and i_in.ready
//   drops once that register is full; nothing is lost or reordered.
// Reset: synchronous, active low. Clears the valid flags of both pipeline
//   registers, the stored length, drop flag and last byte. Header bytes are not
//   cleared; they are always written before being read for a well-formed message.
module sysex_reassembler_reset_detect_core import sxrst_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sxrst_in_if.sink     i_in,
    sxrst_out_if.source  o_out
);

    // input register
    logic                r_in_vld;
    logic [DATA_W-1:0]   r_data;
    logic                r_kind;
    logic [ELEN_W-1:0]   r_elen;
    logic                r_first;
    logic                r_last;
    logic                r_empty;
    logic [TIME_W-1:0]   r_time;

    // message state
    logic [CNT_W-1:0]    r_len,   n_len;
    logic                r_drop,  n_drop;
    logic [DATA_W-1:0]   r_lastb, n_lastb;
    t_hdr                r_hdr,   n_hdr;

    // output register
    logic                r_out_vld;
    logic [TIME_W-1:0]   r_mtime;
    logic [MLEN_W-1:0]   r_mlen;
    logic                r_mrst;

    logic                advance;
    logic                emit;
    logic                emit_rst;
    logic [SUM_W-1:0]    sum;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    assign sum = SUM_W'(r_elen) + SUM_W'(r_len);

    always_comb begin
        n_len    = r_len;
        n_drop   = r_drop;
        n_lastb  = r_lastb;
        n_hdr    = r_hdr;
        emit     = 1'b0;
        emit_rst = 1'b0;

        // event accept/refuse decided on the first byte
        if (r_first) begin
            priority if (sum > SUM_W'(BUFFER_BYTES - 1)) begin
                n_len  = '0;
                n_drop = 1'b1;
            end else if (r_kind == KIND_CONT && r_len == '0) begin
                n_drop = 1'b1;
            end else begin
                n_drop = 1'b0;
                if (r_kind == KIND_START) begin
                    n_len   = CNT_W'(1);
                    n_lastb = SX_START;
                end
            end
        end

        if (!n_drop) begin
            if (!r_empty) begin
                if (n_len < CNT_W'(BUFFER_BYTES - 1)) begin
                    for (int k = 0; k < HDR_N; k++) begin
                        if (n_len == CNT_W'(k + 1))
                            n_hdr[k] = r_data;
                    end
                    n_len = n_len + CNT_W'(1);
                end
                n_lastb = r_data;
            end
            if (r_last && n_len != '0 && n_lastb == SX_END) begin
                emit     = 1'b1;
                emit_rst = detect_reset(n_hdr, n_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data  <= i_in.data_value;
            r_kind  <= i_in.event_kind;
            r_elen  <= i_in.event_length;
            r_first <= i_in.first_of_event;
            r_last  <= i_in.last_of_event;
            r_empty <= i_in.no_payload;
            r_time  <= i_in.event_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_drop  <= 1'b0;
            r_lastb <= '0;
        end else if (advance) begin
            r_len   <= emit ? '0 : n_len;
            r_drop  <= n_drop;
            r_lastb <= n_lastb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance)
            r_hdr <= n_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= emit;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_mtime <= r_time;
            r_mlen  <= MLEN_W'(n_len);
            r_mrst  <= emit_rst;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.message_time   = r_mtime;
    assign o_out.message_length = r_mlen;
    assign o_out.is_reset       = r_mrst;

endmodule

// ===== hdl/sxrst_chk.sv =====
// Port-level checker for the sysex reassembler, bound to the top level.
// Depends on sxrst_pkg and sysex_reassembler_reset_detect_core.
module sxrst_chk import sxrst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [TIME_W-1:0]   i_out_time,
    input  logic [MLEN_W-1:0]   i_out_len,
    input  logic                i_out_rst
);

    // held output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_time) &&
        $stable(i_out_len) && $stable(i_out_rst))
        else $error("output transaction changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a reset message has one of the known lengths
    a_reset_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rst |->
        (i_out_len == MLEN_W'(6) || i_out_len == MLEN_W'(9) ||
         i_out_len == MLEN_W'(10) || i_out_len == MLEN_W'(11)))
        else $error("reset flag on a message of impossible length");

    // an input byte stalled at the port means the output side is stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a pending output");

endmodule

bind sysex_reassembler_reset_detect_core sxrst_chk u_sxrst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_time  (o_out.message_time),
    .i_out_len   (o_out.message_length),
    .i_out_rst   (o_out.is_reset)
);
